### rtl/tft_pkg.sv
package tft_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_DISABLE  = 3'd2,
    REQ_QUERY    = 3'd3,
    REQ_ENUM     = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_INVALID   = 2'd1,
    STS_FULL      = 2'd2,
    STS_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch request word, clear scan flags and counters
    logic pass;    // begin next enumerate pass after current result
    logic rd_en;   // read slot at rd_addr
    logic finish;  // load result word, commit register request
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a word this cycle
    logic more;      // enumerate has further features to list
  } ctl_sts_t;

  localparam logic [30:0] HANDLE_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] NO_HANDLE  = 32'hFFFF_FFFF;
  localparam int          MAX_OUT    = 32;

endpackage

### rtl/tft_ctrl.sv
module tft_ctrl
  import tft_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ctl_sts_t         sts,
  output ctl_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  ctl_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          if (sts.more) begin
            cmd.pass  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = cnt_r;

endmodule

### rtl/tft_dpath.sv
module tft_dpath
  import tft_pkg::*;
#(
  parameter int DEPTH = 32,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  input  logic [IDX_W-1:0]   rd_addr,
  output ctl_sts_t           sts,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_model_id,
  input  logic [4:0]         in_feature_code,
  input  logic signed [31:0] in_handle_in,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_handle_out,
  output logic               out_found,
  output logic [4:0]         out_feature_out,
  output logic [6:0]         out_removed_count,
  output logic               out_last
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EMIT_W = $clog2(MAX_OUT);
  localparam int CMP_W  = (CNT_W > EMIT_W) ? CNT_W + 1 : EMIT_W + 1;

  typedef struct packed {
    logic [15:0] model;
    logic [4:0]  feat;
    logic [30:0] handle;
  } entry_t;

  // Table storage
  entry_t           ent_mem [DEPTH];
  logic [DEPTH-1:0] slot_vld_r;
  entry_t           rd_ent_r;
  logic             rd_vld_r;
  logic             ev_vld_r;
  logic [IDX_W-1:0] ev_idx_r;

  // Latched request
  logic [2:0]  req_type_r;
  logic [15:0] req_model_r;
  logic [4:0]  req_feat_r;
  logic [31:0] req_handle_r;

  // Scan accumulators
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [CNT_W-1:0] rem_cnt_r;
  logic             hit_r;
  logic [CNT_W-1:0] match_cnt_r;
  logic             best_found_r;
  logic [30:0]      best_handle_r;
  logic [4:0]       best_feat_r;
  logic [30:0]      prev_handle_r;
  logic             first_r;
  logic [EMIT_W-1:0] emit_no_r;

  logic [30:0] next_handle_r;
  logic [30:0] stock_limit_r;

  // Result word register
  logic               out_valid_r;
  status_t            out_status_r;
  logic signed [31:0] out_handle_r;
  logic               out_found_r;
  logic [4:0]         out_feat_r;
  logic [6:0]         out_rem_r;
  logic               out_last_r;

  logic ev_live, model_eq, feat_eq;
  logic del_hit, dis_hit, drop, qry_hit, enm_match, enm_cand, free_hit;
  logic reg_ok, commit;

  status_t            res_status;
  logic signed [31:0] res_handle;
  logic               res_found;
  logic [4:0]         res_feat;
  logic [6:0]         res_rem;
  logic               res_last;
  logic               enm_last;
  logic [CMP_W-1:0]   enm_lim;

  // Evaluate the slot word read in the previous cycle
  always_comb begin
    ev_live   = ev_vld_r && rd_vld_r;
    model_eq  = rd_ent_r.model == req_model_r;
    feat_eq   = rd_ent_r.feat == req_feat_r;
    del_hit   = ev_live && (req_type_r == REQ_DELETE) && !req_handle_r[31] &&
                (rd_ent_r.handle == req_handle_r[30:0]);
    dis_hit   = ev_live && (req_type_r == REQ_DISABLE) && (req_feat_r != '0) &&
                feat_eq && (rd_ent_r.handle < stock_limit_r);
    drop      = del_hit || dis_hit;
    qry_hit   = ev_live && (req_type_r == REQ_QUERY) && model_eq && feat_eq;
    enm_match = ev_live && (req_type_r == REQ_ENUM) && model_eq;
    enm_cand  = enm_match && (first_r || (rd_ent_r.handle > prev_handle_r)) &&
                (!best_found_r || (rd_ent_r.handle < best_handle_r));
    free_hit  = ev_vld_r && !rd_vld_r && (req_type_r == REQ_REGISTER) && !free_found_r;
  end

  assign reg_ok = (req_type_r == REQ_REGISTER) && (req_feat_r != '0) && free_found_r &&
                  (next_handle_r != HANDLE_MAX);
  assign commit = cmd.finish && reg_ok;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ent_r <= ent_mem[rd_addr];
      rd_vld_r <= slot_vld_r[rd_addr];
    end
    if (commit) begin
      ent_mem[free_idx_r] <= '{model: req_model_r, feat: req_feat_r, handle: next_handle_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r    <= '0;
      next_handle_r <= '0;
      stock_limit_r <= '0;
      ev_vld_r      <= 1'b0;
    end else begin
      ev_vld_r <= cmd.rd_en;
      if (drop) begin
        slot_vld_r[ev_idx_r] <= 1'b0;
      end
      if (commit) begin
        slot_vld_r[free_idx_r] <= 1'b1;
        next_handle_r          <= next_handle_r + 31'd1;
      end
      if (cfg_we) begin
        stock_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ev_idx_r <= rd_addr;
    end
    if (cmd.start) begin
      req_type_r    <= in_req_type;
      req_model_r   <= in_model_id;
      req_feat_r    <= in_feature_code;
      req_handle_r  <= in_handle_in;
      free_found_r  <= 1'b0;
      rem_cnt_r     <= '0;
      hit_r         <= 1'b0;
      match_cnt_r   <= '0;
      best_found_r  <= 1'b0;
      first_r       <= 1'b1;
      emit_no_r     <= '0;
    end else if (cmd.pass) begin
      // next pass lists the lowest handle above the one just sent
      match_cnt_r   <= '0;
      best_found_r  <= 1'b0;
      first_r       <= 1'b0;
      prev_handle_r <= best_handle_r;
      emit_no_r     <= emit_no_r + EMIT_W'(1);
    end else begin
      if (free_hit) begin
        free_found_r <= 1'b1;
        free_idx_r   <= ev_idx_r;
      end
      if (drop) begin
        rem_cnt_r <= rem_cnt_r + CNT_W'(1);
      end
      if (qry_hit) begin
        hit_r <= 1'b1;
      end
      if (enm_match) begin
        match_cnt_r <= match_cnt_r + CNT_W'(1);
      end
      if (enm_cand) begin
        best_found_r  <= 1'b1;
        best_handle_r <= rd_ent_r.handle;
        best_feat_r   <= rd_ent_r.feat;
      end
    end
  end

  // Build result word from accumulators
  always_comb begin
    enm_lim  = (CMP_W'(match_cnt_r) >= CMP_W'(MAX_OUT)) ? CMP_W'(MAX_OUT)
                                                       : CMP_W'(match_cnt_r);
    enm_last = !best_found_r || ((CMP_W'(emit_no_r) + CMP_W'(1)) == enm_lim);
    res_status = STS_OK;
    res_handle = NO_HANDLE;
    res_found  = 1'b0;
    res_feat   = '0;
    res_rem    = '0;
    res_last   = 1'b1;
    case (req_type_r)
      REQ_REGISTER: begin
        if (req_feat_r == '0) begin
          res_status = STS_INVALID;
        end else if (!free_found_r) begin
          res_status = STS_FULL;
        end else if (next_handle_r == HANDLE_MAX) begin
          res_status = STS_EXHAUSTED;
        end else begin
          res_handle = {1'b0, next_handle_r};
        end
      end
      REQ_DELETE, REQ_DISABLE: begin
        res_rem = 7'(rem_cnt_r);
      end
      REQ_QUERY: begin
        res_found = hit_r;
      end
      REQ_ENUM: begin
        res_found = best_found_r;
        res_feat  = best_found_r ? best_feat_r : '0;
        res_last  = enm_last;
      end
      default: begin
      end
    endcase
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.more     = (req_type_r == REQ_ENUM) && !enm_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
      out_found_r  <= res_found;
      out_feat_r   <= res_feat;
      out_rem_r    <= res_rem;
      out_last_r   <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_handle_out    = out_handle_r;
  assign out_found         = out_found_r;
  assign out_feature_out   = out_feat_r;
  assign out_removed_count = out_rem_r;
  assign out_last          = out_last_r;

endmodule

### rtl/tagged_feature_table.sv
// Table of TABLE_DEPTH (model id, feature code, handle) entries serving five
// request types: register, delete by handle, disable stock, query and
// enumerate. Every request walks the whole table through one read port, one
// slot per cycle; a request word passes from accept through TABLE_DEPTH
// reads, a pipeline drain and a result load, which waits while the output
// register is full and stalled. Enumerate runs one such walk per listed
// feature, picking the lowest handle above the one sent last, for at most 32
// listed features (a model with no entry gives one word with found clear).
// Results leave through an output register, so a new request word is
// accepted while the previous result still waits on out_stall.
// The table is empty right after reset with no clearing pass; stock_limit
// may be written only while no request is in flight.
module tagged_feature_table
  import tft_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // request words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_model_id,
  input  logic [4:0]         in_feature_code,
  input  logic signed [31:0] in_handle_in,
  // stock limit register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_stock_limit,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_handle_out,
  output logic               out_found,
  output logic [4:0]         out_feature_out,
  output logic [6:0]         out_removed_count,
  output logic               out_last
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ctl_cmd_t         cmd;
  ctl_sts_t         sts;
  logic [IDX_W-1:0] rd_addr;

  // The register write is always taken; the user must write only when idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Sequencer: accept, walk slots, drain, load result, repeat for enumerate
  tft_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // Table memory, valid bits, handle counter, match logic, result register
  tft_dpath #(
    .DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_model_id       (in_model_id),
    .in_feature_code   (in_feature_code),
    .in_handle_in      (in_handle_in),
    .cfg_we            (cfg_valid),
    .cfg_data          (cfg_stock_limit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_handle_out    (out_handle_out),
    .out_found         (out_found),
    .out_feature_out   (out_feature_out),
    .out_removed_count (out_removed_count),
    .out_last          (out_last)
  );

endmodule
